// ===== rtl/aitc_pkg.sv =====
package aitc_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    localparam logic [8:0] DEC_MAX    = 9'd255;
    localparam logic [8:0] DEC_SAT    = 9'd256;
    localparam logic [2:0] V4_DOTS    = 3'd3;
    localparam logic [3:0] V6_COLONS  = 4'd7;
    localparam logic [2:0] V4_MAX_LEN = 3'd3;
    localparam logic [2:0] V6_MAX_LEN = 3'd4;
    localparam logic [2:0] LEN_SAT    = 3'd7;
    localparam logic [2:0] DOT_SAT    = 3'd7;
    localparam logic [3:0] COLON_SAT  = 4'd15;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_IPV4  = 2'd1;
    localparam logic [1:0] KIND_IPV6  = 2'd2;

    // decoded character as it travels from front to back
    typedef struct packed {
        logic       is_dot;
        logic       is_colon;
        logic       is_dec;
        logic       is_hex;
        logic       is_zero;
        logic [3:0] digit;
        logic       last;
    } t_char_class;

endpackage

// ===== rtl/aitc_front.sv =====
module aitc_front (
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    output aitc_pkg::t_char_class o_class
);

    logic       w_dec;
    logic [7:0] w_off;

    assign w_dec = (i_char >= aitc_pkg::CHAR_ZERO) && (i_char <= aitc_pkg::CHAR_NINE);
    assign w_off = i_char - aitc_pkg::CHAR_ZERO;

    always_comb begin
        o_class.is_dot   = (i_char == aitc_pkg::CHAR_DOT);
        o_class.is_colon = (i_char == aitc_pkg::CHAR_COLON);
        o_class.is_dec   = w_dec;
        o_class.is_hex   = w_dec
                         || ((i_char >= aitc_pkg::CHAR_LO_A) && (i_char <= aitc_pkg::CHAR_LO_F))
                         || ((i_char >= aitc_pkg::CHAR_UP_A) && (i_char <= aitc_pkg::CHAR_UP_F));
        o_class.is_zero  = (i_char == aitc_pkg::CHAR_ZERO);
        o_class.digit    = w_off[3:0];
        o_class.last     = i_last;
    end

endmodule

// ===== rtl/aitc_fifo.sv =====
module aitc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  aitc_pkg::t_char_class i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output aitc_pkg::t_char_class o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aitc_pkg::t_char_class r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not grow on push");

endmodule

// ===== rtl/aitc_back.sv =====
module aitc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aitc_pkg::t_char_class i_class,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    input  logic                  i_ready
);

    logic [2:0] r_dot_count,   n_dot_count;
    logic [3:0] r_colon_count, n_colon_count;
    logic [2:0] r_len,         n_len;
    logic [8:0] r_dec,         n_dec;
    logic       r_lz,          n_lz;
    logic       r_fail4,       n_fail4;
    logic       r_fail6,       n_fail6;
    logic       r_out_valid,   n_out_valid;
    logic [1:0] r_out_kind,    n_out_kind;

    logic        w_bad4, w_bad6, w_fin4, w_fin6;
    logic [11:0] w_prod;
    logic [1:0]  w_kind;

    assign o_pop   = i_valid && (!i_class.last || !r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;

    // group checks on the group as it stood before this character
    assign w_bad4 = (r_len == '0) || (r_len > aitc_pkg::V4_MAX_LEN)
                 || (r_dec > aitc_pkg::DEC_MAX) || (r_lz && (r_len > 3'd1));
    assign w_bad6 = (r_len == '0) || (r_len > aitc_pkg::V6_MAX_LEN);
    assign w_prod = {3'b000, r_dec} * 12'd10 + {8'h00, i_class.digit};

    always_comb begin
        n_dot_count   = r_dot_count;
        n_colon_count = r_colon_count;
        n_len         = r_len;
        n_dec         = r_dec;
        n_lz          = r_lz;
        n_fail4       = r_fail4;
        n_fail6       = r_fail6;
        if (i_class.is_dot || i_class.is_colon) begin
            n_fail4 = r_fail4 | w_bad4;
            n_fail6 = r_fail6 | w_bad6;
            if (i_class.is_dot && (r_dot_count != aitc_pkg::DOT_SAT)) begin
                n_dot_count = r_dot_count + 3'd1;
            end
            if (i_class.is_colon && (r_colon_count != aitc_pkg::COLON_SAT)) begin
                n_colon_count = r_colon_count + 4'd1;
            end
            n_len = '0;
            n_dec = '0;
            n_lz  = 1'b0;
        end else begin
            if ((r_len == '0) && i_class.is_zero) begin
                n_lz = 1'b1;
            end
            if (!i_class.is_dec) begin
                n_fail4 = 1'b1;
            end else begin
                n_dec = (w_prod > {3'b000, aitc_pkg::DEC_SAT}) ? aitc_pkg::DEC_SAT
                                                              : w_prod[8:0];
            end
            if (!i_class.is_hex) begin
                n_fail6 = 1'b1;
            end
            if (r_len != aitc_pkg::LEN_SAT) begin
                n_len = r_len + 3'd1;
            end
        end
    end

    // closing check of the final group on the updated values
    always_comb begin
        w_fin4 = n_fail4 || (n_len == '0) || (n_len > aitc_pkg::V4_MAX_LEN)
              || (n_dec > aitc_pkg::DEC_MAX) || (n_lz && (n_len > 3'd1));
        w_fin6 = n_fail6 || (n_len == '0) || (n_len > aitc_pkg::V6_MAX_LEN);
        priority if (!w_fin4 && (n_dot_count == aitc_pkg::V4_DOTS) && (n_colon_count == '0)) begin
            w_kind = aitc_pkg::KIND_IPV4;
        end else if (!w_fin6 && (n_colon_count == aitc_pkg::V6_COLONS)
                     && (n_dot_count == '0)) begin
            w_kind = aitc_pkg::KIND_IPV6;
        end else begin
            w_kind = aitc_pkg::KIND_NONE;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_kind  = r_out_kind;
        if (o_pop && i_class.last) begin
            n_out_valid = 1'b1;
            n_out_kind  = w_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_count   <= '0;
            r_colon_count <= '0;
            r_len         <= '0;
            r_dec         <= '0;
            r_lz          <= 1'b0;
            r_fail4       <= 1'b0;
            r_fail6       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_class.last) begin
                    r_dot_count   <= '0;
                    r_colon_count <= '0;
                    r_len         <= '0;
                    r_dec         <= '0;
                    r_lz          <= 1'b0;
                    r_fail4       <= 1'b0;
                    r_fail6       <= 1'b0;
                end else begin
                    r_dot_count   <= n_dot_count;
                    r_colon_count <= n_colon_count;
                    r_len         <= n_len;
                    r_dec         <= n_dec;
                    r_lz          <= n_lz;
                    r_fail4       <= n_fail4;
                    r_fail6       <= n_fail6;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_class.last) |=> (r_dot_count == '0 && r_colon_count == '0
                                     && r_len == '0 && !r_fail4 && !r_fail6))
        else $error("string state not cleared after final beat");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_kind != 2'b11))
        else $error("illegal address kind");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(o_pop && i_class.last))
        else $error("pending result overwritten");

endmodule

// ===== rtl/ip_address_text_classifier.sv =====
// Classifies an address string streamed one character per beat on s_axis (tlast on
// the final character) as dotted IPv4, colon IPv6 or neither; one result beat per
// string on m_axis. The block sustains one character per cycle unless a final character waits
// on a pending result: the group update in the back end is combinational, and it takes one queued
// character each cycle. A short queue of FIFO_DEPTH decoded characters sits between the
// character decoder and that back end, and the result sits in an output register, so
// a stalled m_axis does not stop input until the queue fills. The result for a string
// is registered once the back end pops its final character and the output is free.
module ip_address_text_classifier #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] address_kind, [7:2] zero
);

    aitc_pkg::t_char_class w_front_class;
    aitc_pkg::t_char_class w_queue_class;
    logic                  w_full, w_queue_valid, w_pop;
    logic [1:0]            w_kind;

    aitc_front u_front (
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_class (w_front_class)
    );

    aitc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (w_front_class),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_data  (w_queue_class)
    );

    aitc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_queue_valid),
        .i_class (w_queue_class),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_kind  (w_kind),
        .i_ready (m_axis_tready)
    );

    assign s_axis_tready = !w_full;
    assign m_axis_tdata  = {6'b000000, w_kind};

endmodule
